### rtl/core/tlpts_pkg.sv
// Package for the two-level priority task scheduler: sizes, item types,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package tlpts_pkg;

   localparam int MAX_TASKS = 64;
   localparam int IDX_W     = $clog2(MAX_TASKS);
   localparam int CNT_W     = IDX_W + 1;
   localparam int IN_TIME_W = 20;
   localparam int OUT_TIME_W = 27;

   typedef struct packed {
      logic [IN_TIME_W-1:0] arrival_time;
      logic [IN_TIME_W-1:0] run_time;
      logic                 low_priority;
      logic                 last_task;
   } req_type;

   typedef struct packed {
      logic [OUT_TIME_W-1:0] completion_time;
      logic                  last_result;
   } rsp_type;

   typedef struct packed {
      logic [IN_TIME_W-1:0] arrive;
      logic [IN_TIME_W-1:0] run;
      logic [IDX_W-1:0]     num;
   } job_type;

   typedef enum logic [3:0] {
      ST_LOAD  = 4'b0001,
      ST_PRIME = 4'b0010,
      ST_SCHED = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   typedef struct packed {
      logic load;
      logic serve;
      logic emit;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic done;
   } status_type;

endpackage

### rtl/core/tlpts_ctrl.sv
// Controller for the two-level priority task scheduler: load, prime, schedule, emit.
// Depends on tlpts_pkg.
module tlpts_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 last_task,
   input  tlpts_pkg::status_type status,
   output logic                 busy,
   output tlpts_pkg::cmd_type   cmd
);

   tlpts_pkg::state_type state_ff, state_in;
   logic accept;

   assign busy   = (state_ff != tlpts_pkg::ST_LOAD);
   assign accept = start && !busy;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      case (state_ff)
         tlpts_pkg::ST_LOAD: begin
            cmd.load = accept;
            if (accept && last_task) state_in = tlpts_pkg::ST_PRIME;
         end
         tlpts_pkg::ST_PRIME: begin
            state_in = tlpts_pkg::ST_SCHED;
         end
         tlpts_pkg::ST_SCHED: begin
            cmd.serve = 1'b1;
            if (status.done) state_in = tlpts_pkg::ST_EMIT;
         end
         tlpts_pkg::ST_EMIT: begin
            cmd.emit  = 1'b1;
            cmd.clear = status.done;
            if (status.done) state_in = tlpts_pkg::ST_LOAD;
         end
         default: begin
            state_in = tlpts_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tlpts_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/tlpts_dp.sv
// Datapath for the two-level priority task scheduler: both FIFOs, the completion
// store, counters, finish time and the result register. Depends on tlpts_pkg.
module tlpts_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  tlpts_pkg::cmd_type    cmd,
   input  tlpts_pkg::req_type    req_data,
   output tlpts_pkg::status_type status,
   output logic                  rsp_strobe,
   output tlpts_pkg::rsp_type    rsp_data
);

   localparam int CNT_W = tlpts_pkg::CNT_W;
   localparam int IDX_W = tlpts_pkg::IDX_W;
   localparam int OTW   = tlpts_pkg::OUT_TIME_W;
   localparam int ITW   = tlpts_pkg::IN_TIME_W;

   tlpts_pkg::job_type high_mem [tlpts_pkg::MAX_TASKS];
   tlpts_pkg::job_type low_mem  [tlpts_pkg::MAX_TASKS];
   logic [OTW-1:0]     comp_mem [tlpts_pkg::MAX_TASKS];

   logic [CNT_W-1:0] high_head_ff, high_head_in, high_tail_ff, high_tail_in;
   logic [CNT_W-1:0] low_head_ff, low_head_in, low_tail_ff, low_tail_in;
   logic [CNT_W-1:0] count_ff, count_in, k_ff, k_in;
   logic [OTW-1:0]   finish_ff, finish_in;
   tlpts_pkg::job_type high_rd_ff, low_rd_ff, job_new, job_sel;
   logic [OTW-1:0]   comp_rd_ff;
   logic             strobe_ff, last_ff;

   logic             have_high, have_low, pick_low, room, done;
   logic [OTW-1:0]   arr_ext, run_ext, begin_time;
   logic [OTW:0]     sum;

   assign have_high = high_head_ff < high_tail_ff;
   assign have_low  = low_head_ff < low_tail_ff;
   assign pick_low  = !have_high ||
                      (have_low && ({{(OTW-ITW){1'b0}}, high_rd_ff.arrive} > finish_ff) &&
                       (high_rd_ff.arrive > low_rd_ff.arrive));
   assign job_sel    = pick_low ? low_rd_ff : high_rd_ff;
   assign arr_ext    = {{(OTW-ITW){1'b0}}, job_sel.arrive};
   assign run_ext    = {{(OTW-ITW){1'b0}}, job_sel.run};
   assign begin_time = (finish_ff > arr_ext) ? finish_ff : arr_ext;
   assign sum        = {1'b0, begin_time} + {1'b0, run_ext};

   assign room = count_ff < CNT_W'(tlpts_pkg::MAX_TASKS);
   assign done = (k_ff == count_ff - CNT_W'(1));
   assign status.done = done;

   assign job_new.arrive = req_data.arrival_time;
   assign job_new.run    = req_data.run_time;
   assign job_new.num    = count_ff[IDX_W-1:0];

   always_comb begin
      high_head_in = high_head_ff;
      high_tail_in = high_tail_ff;
      low_head_in  = low_head_ff;
      low_tail_in  = low_tail_ff;
      count_in     = count_ff;
      k_in         = k_ff;
      finish_in    = finish_ff;
      if (cmd.load && room) begin
         count_in = count_ff + CNT_W'(1);
         if (req_data.low_priority) low_tail_in = low_tail_ff + CNT_W'(1);
         else                       high_tail_in = high_tail_ff + CNT_W'(1);
      end
      if (cmd.serve) begin
         finish_in = sum[OTW-1:0];
         k_in      = done ? '0 : k_ff + CNT_W'(1);
         if (pick_low) low_head_in = low_head_ff + CNT_W'(1);
         else          high_head_in = high_head_ff + CNT_W'(1);
      end
      if (cmd.emit) begin
         k_in = done ? '0 : k_ff + CNT_W'(1);
      end
      if (cmd.clear) begin
         high_head_in = '0;
         high_tail_in = '0;
         low_head_in  = '0;
         low_tail_in  = '0;
         count_in     = '0;
         finish_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_head_ff <= '0;
         high_tail_ff <= '0;
         low_head_ff  <= '0;
         low_tail_ff  <= '0;
         count_ff     <= '0;
         k_ff         <= '0;
         finish_ff    <= '0;
         strobe_ff    <= 1'b0;
      end else begin
         high_head_ff <= high_head_in;
         high_tail_ff <= high_tail_in;
         low_head_ff  <= low_head_in;
         low_tail_ff  <= low_tail_in;
         count_ff     <= count_in;
         k_ff         <= k_in;
         finish_ff    <= finish_in;
         strobe_ff    <= cmd.emit;
      end
   end

   // FIFO memories: write at the tail, read at the next head
   always_ff @(posedge clock) begin
      if (cmd.load && room && !req_data.low_priority) begin
         high_mem[high_tail_ff[IDX_W-1:0]] <= job_new;
      end
      high_rd_ff <= high_mem[high_head_in[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.load && room && req_data.low_priority) begin
         low_mem[low_tail_ff[IDX_W-1:0]] <= job_new;
      end
      low_rd_ff <= low_mem[low_head_in[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.serve) begin
         comp_mem[job_sel.num] <= sum[OTW-1:0];
      end
      comp_rd_ff <= comp_mem[k_ff[IDX_W-1:0]];
      last_ff    <= done;
   end

   assign rsp_strobe               = strobe_ff;
   assign rsp_data.completion_time = comp_rd_ff;
   assign rsp_data.last_result     = last_ff;

   a_strobe_after_emit: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> $past(cmd.emit))
      else $error("result strobe without an emit cycle");

   a_tails_match_count: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, high_tail_ff} + {1'b0, low_tail_ff}) == {1'b0, count_ff})
      else $error("queue tails do not add up to the task count");

   a_heads_within_tails: assert property (@(posedge clock) disable iff (reset)
      (high_head_ff <= high_tail_ff) && (low_head_ff <= low_tail_ff))
      else $error("queue head overtook its tail");

   a_serve_has_task: assert property (@(posedge clock) disable iff (reset)
      cmd.serve |-> (have_high || have_low))
      else $error("schedule cycle with both queues empty");

endmodule

### rtl/core/two_level_priority_task_scheduler.sv
// Two-level non-preemptive priority task scheduler, one server.
// Each task is loaded, then scheduled, then its completion time emitted; after the last
// item the batch primes the memory reads, schedules every task, then emits the results.
// A new batch is not taken until the last result of the previous one has been emitted.
// Results are strobed for one cycle each; the receiver cannot stall them.
// Reset (synchronous, active high) empties both queues; memories are not cleared.
module two_level_priority_task_scheduler (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  tlpts_pkg::req_type req_data,
   output logic               rsp_strobe,
   output tlpts_pkg::rsp_type rsp_data
);

   tlpts_pkg::cmd_type    cmd;
   tlpts_pkg::status_type status;

   // Sequence the batch: take items until the last one, prime the head reads,
   // serve one task a cycle, then stream completion times out in input order.
   tlpts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .last_task (req_data.last_task),
      .status    (status),
      .busy      (busy),
      .cmd       (cmd)
   );

   // Hold the queues, finish time and completion store; pick the high head unless the high
   // queue is empty, or the high head has not arrived yet and the low head arrived earlier.
   tlpts_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_data   (req_data),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
